>>> rtl/kps_pkg.sv
// ---------------------------------------------------------------------------
// kps_pkg: shared types and constants for the keypad scanner
// Holds the command word passed from the front end to the back end and the
// fixed 4x4 key table.
// ---------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 5;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

  localparam logic REQ_ROW_EVENT = 1'b0;
  localparam logic REQ_GET_KEY   = 1'b1;

  typedef struct packed {
    logic       is_get;
    logic [7:0] key;
  } kps_cmd_t;

  // Key character for a row and a column, row-major "123A 456B 789C *0#D".
  function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] ch;
    case ({row, col})
      4'd0:    ch = "1";
      4'd1:    ch = "2";
      4'd2:    ch = "3";
      4'd3:    ch = "A";
      4'd4:    ch = "4";
      4'd5:    ch = "5";
      4'd6:    ch = "6";
      4'd7:    ch = "B";
      4'd8:    ch = "7";
      4'd9:    ch = "8";
      4'd10:   ch = "9";
      4'd11:   ch = "C";
      4'd12:   ch = "*";
      4'd13:   ch = "0";
      4'd14:   ch = "#";
      4'd15:   ch = "D";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/kps_front.sv
// ---------------------------------------------------------------------------
// kps_front: debounce and classification
// Accepts input words, applies the debounce window to row events, picks the
// key from the first low column and issues push or get commands.
// ---------------------------------------------------------------------------
module kps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                debounce_we,
  input  logic [15:0]         debounce_ms,
  input  logic                in_take,
  input  logic                req_type,
  input  logic [1:0]          row_index,
  input  logic [3:0]          column_levels,
  input  logic [31:0]         timestamp_ms,
  output logic                cmd_wr,
  output kps_pkg::kps_cmd_t   cmd
);
  import kps_pkg::*;

  logic [15:0] debounce;
  logic [31:0] last_time;
  logic [31:0] elapsed;
  logic        settled;
  logic        any_low;
  logic [1:0]  col;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce  <= DEBOUNCE_RESET;
      last_time <= 32'd0;
    end else begin
      if (debounce_we) begin
        debounce <= debounce_ms;
      end
      // Every row event moves the stored time, accepted or not.
      if (in_take && req_type == REQ_ROW_EVENT) begin
        last_time <= timestamp_ms;
      end
    end
  end

  always_comb begin
    elapsed = timestamp_ms - last_time;
    settled = elapsed >= {16'd0, debounce};
    any_low = column_levels != 4'hF;
    col     = 2'd0;
    if (!column_levels[0]) begin
      col = 2'd0;
    end else if (!column_levels[1]) begin
      col = 2'd1;
    end else if (!column_levels[2]) begin
      col = 2'd2;
    end else begin
      col = 2'd3;
    end
  end

  assign cmd.is_get = req_type == REQ_GET_KEY;
  assign cmd.key    = key_lookup(row_index, col);
  assign cmd_wr     = in_take && (req_type == REQ_GET_KEY || (settled && any_low));

endmodule

>>> rtl/kps_cmd_queue.sv
// ---------------------------------------------------------------------------
// kps_cmd_queue: two-entry command queue
// Decouples the front end from the back end so either side may stall.
// ---------------------------------------------------------------------------
module kps_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  kps_pkg::kps_cmd_t wr_cmd,
  output logic              full,
  input  logic              rd,
  output logic              rd_valid,
  output kps_pkg::kps_cmd_t rd_cmd
);
  import kps_pkg::*;

  kps_cmd_t    entry [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wptr] <= wr_cmd;
    end
  end

  assign full     = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_cmd   = entry[rptr];

endmodule

>>> rtl/kps_back.sv
// ---------------------------------------------------------------------------
// kps_back: key storage and result queue
// Carries out push and get commands on the key queue and holds up to two
// finished result words for the consumer.
// ---------------------------------------------------------------------------
module kps_back #(
  parameter int unsigned FIFO_DEPTH = kps_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  kps_pkg::kps_cmd_t cmd,
  output logic              cmd_rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        key_char,
  output logic              key_present
);
  import kps_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);

  logic [7:0]       key_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] kcount;

  logic [7:0]       res_char [2];
  logic             res_present [2];
  logic             res_wptr;
  logic             res_rptr;
  logic [1:0]       res_count;

  logic             res_full;
  logic             push_key;
  logic             pop_key;
  logic             res_wr;
  logic             res_rd;

  assign res_full = res_count == 2'd2;
  assign cmd_rd   = cmd_valid && !(cmd.is_get && res_full);
  assign push_key = cmd_rd && !cmd.is_get && kcount != FULL_CNT;
  assign pop_key  = cmd_rd && cmd.is_get && kcount != '0;
  assign res_wr   = cmd_rd && cmd.is_get;
  assign res_rd   = pop && res_count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      kcount    <= '0;
      res_wptr  <= 1'b0;
      res_rptr  <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (push_key) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      end
      if (pop_key) begin
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      end
      kcount <= kcount + CNT_W'(push_key) - CNT_W'(pop_key);
      if (res_wr) begin
        res_wptr <= ~res_wptr;
      end
      if (res_rd) begin
        res_rptr <= ~res_rptr;
      end
      res_count <= res_count + {1'b0, res_wr} - {1'b0, res_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (push_key) begin
      key_mem[tail] <= cmd.key;
    end
    if (res_wr) begin
      res_char[res_wptr]    <= (kcount != '0) ? key_mem[head] : 8'd0;
      res_present[res_wptr] <= kcount != '0;
    end
  end

  assign empty       = res_count == 2'd0;
  assign key_char    = res_char[res_rptr];
  assign key_present = res_present[res_rptr];

  a_kcount_bound: assert property (@(posedge clk) disable iff (rst)
    kcount <= FULL_CNT)
    else $error("key queue count exceeds its depth");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= 2'd2)
    else $error("result queue count exceeds two");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push_key && kcount == '0 |=> kcount == CNT_W'(1))
    else $error("push into empty key queue was lost");

  a_get_stall: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.is_get && res_full |-> !pop_key)
    else $error("key popped while result queue full");

endmodule

>>> rtl/matrix_keypad_scanner_fifo.sv
// ---------------------------------------------------------------------------
// matrix_keypad_scanner_fifo: 4x4 keypad scanner with a key queue
// Debounces row events, maps the pressed key to a character and queues it;
// get-key requests pop the oldest character.
// ---------------------------------------------------------------------------
// Result path: an accepted get-key request passes through the command queue
//   and then the result register, and waits while the result queue is full.
// Throughput: one input word per cycle, sustained, while the consumer pops;
//   the two-entry command and result queues absorb short stalls.
// Reset (rst, synchronous): debounce returns to 50 ms, the stored event time
//   to 0, and all queues empty; key storage itself is not cleared.
module matrix_keypad_scanner_fifo #(
  parameter int unsigned FIFO_DEPTH = kps_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: debounce threshold in milliseconds.
  input  logic        debounce_we,
  input  logic [15:0] debounce_ms,
  // Input side, queue style.
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [1:0]  row_index,
  input  logic [3:0]  column_levels,
  input  logic [31:0] timestamp_ms,
  // Result side, queue style.
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  key_char,
  output logic        key_present
);
  import kps_pkg::*;

  logic     in_take;
  logic     cmd_wr;
  kps_cmd_t cmd_in;
  logic     cmd_full;
  logic     cmd_valid;
  logic     cmd_rd;
  kps_cmd_t cmd_out;

  // The input is held off only when the command queue has no room. A word
  // that produces no command (a bounced or keyless row event) is still taken.
  assign full    = cmd_full;
  assign in_take = push && !cmd_full;

  // Front end: debounce check, column priority encode and key lookup.
  kps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .debounce_we   (debounce_we),
    .debounce_ms   (debounce_ms),
    .in_take       (in_take),
    .req_type      (req_type),
    .row_index     (row_index),
    .column_levels (column_levels),
    .timestamp_ms  (timestamp_ms),
    .cmd_wr        (cmd_wr),
    .cmd           (cmd_in)
  );

  // Short queue that lets the front and back ends stall independently.
  kps_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (cmd_wr),
    .wr_cmd   (cmd_in),
    .full     (cmd_full),
    .rd       (cmd_rd),
    .rd_valid (cmd_valid),
    .rd_cmd   (cmd_out)
  );

  // Back end: key storage and the result words waiting for pop.
  kps_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_out),
    .cmd_rd      (cmd_rd),
    .empty       (empty),
    .pop         (pop),
    .key_char    (key_char),
    .key_present (key_present)
  );

endmodule
